>>> rtl/mfs_pkg.sv
// package for the maximum frequency stack
// sizes, operation and status codes, cell control struct; no dependencies
package mfs_pkg;

  localparam int DEPTH      = 64;
  localparam int VALUE_BITS = 32;
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LVL_W      = CNT_W;
  localparam int GROUP      = 8;
  localparam int NGROUPS    = (DEPTH + GROUP - 1) / GROUP;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic [VALUE_BITS-1:0] key_value;
    logic [LVL_W-1:0]      key_level;
    logic                  on_level;
    logic [CNT_W-1:0]      count;
    logic                  shift_en;
    logic [IDX_W-1:0]      pick;
    logic                  write_en;
    logic [LVL_W-1:0]      new_level;
  } cell_ctrl_t;

endpackage

>>> rtl/mfs_cell.sv
// one entry cell of the stack chain: value and level, tag compare, neighbor load
// depends on mfs_pkg
module mfs_cell
  import mfs_pkg::*;
(
  input  logic                  clk,
  input  logic [IDX_W-1:0]      cell_idx,
  input  cell_ctrl_t            ctrl,
  input  logic [VALUE_BITS-1:0] nxt_value,
  input  logic [LVL_W-1:0]      nxt_level,
  output logic [VALUE_BITS-1:0] value,
  output logic [LVL_W-1:0]      level,
  output logic                  match
);

  logic held;

  // entry is live when its index is below the fill count
  assign held  = CNT_W'(cell_idx) < ctrl.count;
  assign match = held && (ctrl.on_level ? (level == ctrl.key_level)
                                        : (value == ctrl.key_value));

  // close the gap on a pop, or take a new push at the fill point
  always_ff @(posedge clk) begin
    if (ctrl.shift_en && (cell_idx >= ctrl.pick)) begin
      value <= nxt_value;
      level <= nxt_level;
    end else if (ctrl.write_en && (CNT_W'(cell_idx) == ctrl.count)) begin
      value <= ctrl.key_value;
      level <= ctrl.new_level;
    end
  end

endmodule

>>> rtl/mfs_find.sv
// two-stage registered search for the highest matching cell index
// depends on mfs_pkg
module mfs_find
  import mfs_pkg::*;
(
  input  logic             clk,
  input  logic [DEPTH-1:0] match,
  output logic             hit,
  output logic [IDX_W-1:0] idx
);

  localparam int PAD = NGROUPS * GROUP;

  logic [PAD-1:0]   match_pad;
  logic [NGROUPS-1:0] grp_hit, grp_hit_next;
  logic [IDX_W-1:0] grp_idx [NGROUPS];
  logic [IDX_W-1:0] grp_idx_next [NGROUPS];
  logic             hit_next;
  logic [IDX_W-1:0] idx_next;

  assign match_pad = PAD'(match);

  // stage one: highest match inside each group of eight
  always_comb begin
    for (int g = 0; g < NGROUPS; g++) begin
      grp_hit_next[g] = 1'b0;
      grp_idx_next[g] = '0;
      for (int j = 0; j < GROUP; j++) begin
        if (match_pad[g*GROUP + j]) begin
          grp_hit_next[g] = 1'b1;
          grp_idx_next[g] = IDX_W'(g*GROUP + j);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    grp_hit <= grp_hit_next;
    for (int g = 0; g < NGROUPS; g++) begin
      grp_idx[g] <= grp_idx_next[g];
    end
  end

  // stage two: highest group with a match
  always_comb begin
    hit_next = 1'b0;
    idx_next = '0;
    for (int g = 0; g < NGROUPS; g++) begin
      if (grp_hit[g]) begin
        hit_next = 1'b1;
        idx_next = grp_idx[g];
      end
    end
  end

  always_ff @(posedge clk) begin
    hit <= hit_next;
    idx <= idx_next;
  end

endmodule

>>> rtl/max_frequency_stack_core.sv
// maximum frequency stack: controller, cell chain and search tree
// depends on mfs_pkg, mfs_cell, mfs_find
//
//   channel  dir  handshake          payload
//   s_*      in   s_tvalid/s_tready  tuser[0] operation, tdata[31:0] push_value
//   m_*      out  m_tvalid/m_tready  tuser[1:0] status, tdata[31:0] popped_value
//
// one request at a time: after the accept a push steps through FIND, SELECT, APPLY, EXEC
// and DONE, a pop through FIND, SELECT, APPLY, EXEC, CHECK and DONE, and a push on a full
// or a pop on an empty store goes straight to DONE; the result is registered out of DONE;
// the steps follow the two-stage search tree and the entry read before the chain update.
// rst is synchronous and clears the fill count, the top level and the controller.
// the result waits in an output register; the controller holds in its last
// state while that register is still full and m_tready is low.
module max_frequency_stack_core
  import mfs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] push_value
  input  logic [0:0]  s_tuser,   // [0] operation
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] popped_value
  output logic [1:0]  m_tuser    // [1:0] status
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_FIND   = 7'b0000010,
    S_SELECT = 7'b0000100,
    S_APPLY  = 7'b0001000,
    S_EXEC   = 7'b0010000,
    S_CHECK  = 7'b0100000,
    S_DONE   = 7'b1000000
  } state_t;

  state_t                state, state_next;
  logic [CNT_W-1:0]      count, count_next;
  logic [LVL_W-1:0]      top_level, top_level_next;
  logic                  op;
  logic [VALUE_BITS-1:0] val;
  logic [IDX_W-1:0]      pick;
  logic                  found;
  logic [VALUE_BITS-1:0] sel_value;
  logic [LVL_W-1:0]      sel_level;
  logic [31:0]           res_value;
  logic [1:0]            res_status;
  logic [LVL_W-1:0]      new_level;
  logic                  remain;
  logic                  s_fire, out_free;

  cell_ctrl_t            ctrl;
  logic [DEPTH-1:0]      match;
  logic [VALUE_BITS-1:0] cell_value [DEPTH];
  logic [LVL_W-1:0]      cell_level [DEPTH];
  logic                  find_hit;
  logic [IDX_W-1:0]      find_idx;

  assign s_tready = (state == S_IDLE);
  assign s_fire   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign remain   = |match;
  assign new_level = found ? (sel_level + LVL_W'(1)) : LVL_W'(1);

  // broadcast control to the chain
  always_comb begin
    ctrl.key_value = val;
    ctrl.key_level = top_level;
    ctrl.on_level  = (op == OP_POP);
    ctrl.count     = count;
    ctrl.shift_en  = (state == S_EXEC) && (op == OP_POP);
    ctrl.pick      = pick;
    ctrl.write_en  = (state == S_EXEC) && (op == OP_PUSH);
    ctrl.new_level = new_level;
  end

  // cell chain, each cell loads from its upper neighbor on a pop
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [VALUE_BITS-1:0] up_value;
    logic [LVL_W-1:0]      up_level;
    if (i == DEPTH - 1) begin : g_end
      assign up_value = '0;
      assign up_level = '0;
    end else begin : g_mid
      assign up_value = cell_value[i+1];
      assign up_level = cell_level[i+1];
    end
    mfs_cell u_cell (
      .clk       (clk),
      .cell_idx  (IDX_W'(i)),
      .ctrl      (ctrl),
      .nxt_value (up_value),
      .nxt_level (up_level),
      .value     (cell_value[i]),
      .level     (cell_level[i]),
      .match     (match[i])
    );
  end

  mfs_find u_find (
    .clk   (clk),
    .match (match),
    .hit   (find_hit),
    .idx   (find_idx)
  );

  // next state, count and top level
  always_comb begin
    state_next     = state;
    count_next     = count;
    top_level_next = top_level;
    unique case (state)
      S_IDLE: begin
        if (s_fire) begin
          if (s_tuser[0] == OP_PUSH && count == CNT_W'(DEPTH)) begin
            state_next = S_DONE;
          end else if (s_tuser[0] == OP_POP && count == '0) begin
            state_next = S_DONE;
          end else begin
            state_next = S_FIND;
          end
        end
      end
      S_FIND:   state_next = S_SELECT;
      S_SELECT: state_next = S_APPLY;
      S_APPLY:  state_next = S_EXEC;
      S_EXEC: begin
        if (op == OP_POP) begin
          count_next = count - CNT_W'(1);
          state_next = S_CHECK;
        end else begin
          count_next = count + CNT_W'(1);
          if (new_level > top_level) top_level_next = new_level;
          state_next = S_DONE;
        end
      end
      S_CHECK: begin
        if (!remain && top_level != '0) top_level_next = top_level - LVL_W'(1);
        state_next = S_DONE;
      end
      S_DONE: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      top_level <= '0;
      m_tvalid  <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      top_level <= top_level_next;
      if (state == S_DONE && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // request capture, entry read and result payload
  always_ff @(posedge clk) begin
    if (s_fire) begin
      op        <= s_tuser[0];
      val       <= VALUE_BITS'(s_tdata);
      res_value <= '0;
      if (s_tuser[0] == OP_PUSH && count == CNT_W'(DEPTH)) begin
        res_status <= ST_FULL;
      end else if (s_tuser[0] == OP_POP && count == '0) begin
        res_status <= ST_EMPTY;
      end else begin
        res_status <= ST_DONE;
      end
    end
    if (state == S_APPLY) begin
      found <= find_hit;
      if (find_hit) begin
        pick      <= find_idx;
        sel_value <= cell_value[find_idx];
        sel_level <= cell_level[find_idx];
      end else begin
        pick      <= IDX_W'(count - CNT_W'(1));
        sel_value <= cell_value[IDX_W'(count - CNT_W'(1))];
        sel_level <= cell_level[IDX_W'(count - CNT_W'(1))];
      end
    end
    if (state == S_EXEC && op == OP_POP) begin
      res_value <= 32'(sel_value);
    end
    if (state == S_DONE && out_free) begin
      m_tdata <= res_value;
      m_tuser <= res_status;
    end
  end

`ifndef NO_ASSERTIONS
  // fill count stays within the store
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("fill count beyond store depth");

  // levels never exceed the number of held entries between requests
  a_top_le_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (top_level <= LVL_W'(count)))
    else $error("top level above entry count");

  // an empty store has no top level once a request completes
  a_empty_top: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && count == '0) |-> (top_level == '0))
    else $error("top level left on empty store");

  // a pop always finds an entry at the top level
  a_pop_found: assert property (@(posedge clk) disable iff (rst)
    (state == S_EXEC && op == OP_POP) |-> found)
    else $error("pop found no entry at top level");
`endif

endmodule
